FILE: rtl/core/bfba_pkg.sv
`default_nettype none
package bfba_pkg;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOT_USED = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_MISALIGN = 3'd4;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [11:0] block_index;
    logic        all_free;
    logic        all_used;
  } out_t;

  // Result of the shared divider; done pulses for one cycle.
  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [15:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/bfba_ram.sv
`default_nettype none
module bfba_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/core/bfba_div.sv
`default_nettype none
module bfba_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [31:0]           dividend_i,
  input  wire logic [15:0]           divisor_i,
  output bfba_pkg::div_res_t         res_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dsr_q, dsr_d;
  logic [16:0] trial;
  logic        ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], ge};
      rem_d = ge ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;
  assign res_o.rem  = rem_q;

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_fixed_block_allocator_core.sv
// Fixed-size block allocator with a one-bit-per-block free map.
// Input channel: in_valid_i / in_stall_o carry one request beat (op, address).
// Output channel: out_valid_o / out_stall_i carry one result beat per request.
// Configuration channel: cfg_valid_i / cfg_ready_o write base_address (index 0)
// or block_size (index 1); it is always ready and should be used while idle.
// The free map lives in a synchronous RAM of map bytes, one row per eight
// blocks; its read data is registered and arrives in the cycle after the
// address is given. Alloc scans the map row by row up to the first free
// block; free and contains wait on the 32-step bit-serial divider that turns
// an offset into a block index.
// A request is taken only while the core is idle, so one request is in flight.
// A finished result sits in the output register; the core takes the next
// request while that beat waits, and holds a second result until the first
// one leaves while out_stall_i is high.
// After reset a clearing pass writes every map row to all free while
// in_stall_o is high; registers return to base 0 and block size 16.
`default_nettype none
module bitmap_fixed_block_allocator_core #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire bfba_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bfba_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  localparam int Rows = (NUM_BLOCKS + 7) / 8;
  localparam int RW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int CW   = $clog2(NUM_BLOCKS + 1);
  localparam logic [31:0] MapBytes = 32'(NUM_BLOCKS / 8);
  localparam logic [31:0] NumBlk32 = 32'(NUM_BLOCKS);
  localparam logic [12:0] NumBlk13 = 13'(NUM_BLOCKS);
  localparam logic [CW-1:0] NumBlkC = CW'(NUM_BLOCKS);
  localparam logic [RW-1:0] LastRow = RW'(Rows - 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_CK = 4'd4;
  localparam logic [3:0] S_FREE_RD = 4'd5;
  localparam logic [3:0] S_FREE_CK = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_ADDR    = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   base_q;
  logic [15:0]   bsize_q;
  logic [1:0]    op_q, op_d;
  logic [31:0]   off_q, off_d;
  logic [28:0]   span_q, span_d;
  logic [12:0]   idx_q, idx_d;
  logic [28:0]   prod_q, prod_d;
  logic [2:0]    res_st_q, res_st_d;
  logic [31:0]   res_addr_q, res_addr_d;
  logic [11:0]   res_idx_q, res_idx_d;
  logic          out_valid_q, out_valid_d;
  bfba_pkg::out_t out_q, out_d;

  logic [15:0]   bs_eff;
  logic [31:0]   off_in;
  logic          accept;
  logic          div_start;
  bfba_pkg::div_res_t div_res;

  logic          ram_we;
  logic [RW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [7:0]    row_valid;
  logic [7:0]    row_free;
  logic [2:0]    first_k;
  logic [7:0]    q_mask;
  logic          out_load;

  assign bs_eff    = (bsize_q == 16'd0) ? 16'd1 : bsize_q;
  assign off_in    = in_data_i.address - base_q - MapBytes;
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign div_start = accept && (in_data_i.op == bfba_pkg::OP_FREE ||
                                in_data_i.op == bfba_pkg::OP_CONTAINS);

  // Blocks past NUM_BLOCKS in the last row never count as free.
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      row_valid[p] = (14'({row_q, 3'b000}) + 14'(7 - p)) < {1'b0, NumBlk13};
    end
  end
  assign row_free = ram_rdata & row_valid;

  // Bit 7 is the lowest block of a row, so the highest set bit wins.
  always_comb begin
    first_k = 3'd0;
    for (int p = 0; p < 8; p++) begin
      if (row_free[p]) begin
        first_k = 3'(7 - p);
      end
    end
  end

  assign q_mask    = 8'h80 >> div_res.quo[2:0];
  assign ram_raddr = (state_q == S_FREE_RD) ? div_res.quo[RW+2:3] : row_q;
  assign out_load  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    off_d      = off_q;
    span_d     = span_q;
    idx_d      = idx_q;
    prod_d     = prod_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_idx_d  = res_idx_q;
    out_d      = out_q;
    out_valid_d = out_valid_q;
    ram_we     = 1'b0;
    ram_waddr  = row_q;
    ram_wdata  = 8'hFF;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        row_d  = row_q + RW'(1);
        if (row_q == LastRow) begin
          row_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d       = in_data_i.op;
          off_d      = off_in;
          span_d     = {16'b0, NumBlk13} * {13'b0, bs_eff};
          res_st_d   = bfba_pkg::ST_OK;
          res_addr_d = '0;
          res_idx_d  = '0;
          row_d      = '0;
          case (in_data_i.op)
            bfba_pkg::OP_ALLOC: begin
              if (cnt_q == '0) begin
                res_st_d = bfba_pkg::ST_FULL;
                state_d  = S_OUT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            bfba_pkg::OP_FREE:     state_d = S_DIV;
            bfba_pkg::OP_CONTAINS: state_d = S_DIV;
            default:               state_d = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (op_q == bfba_pkg::OP_FREE) begin
            if (div_res.quo >= NumBlk32) begin
              res_st_d = bfba_pkg::ST_RANGE;
              state_d  = S_OUT;
            end else begin
              res_idx_d = div_res.quo[11:0];
              state_d   = S_FREE_RD;
            end
          end else begin
            if (off_q >= {3'b0, span_q}) begin
              res_st_d = bfba_pkg::ST_RANGE;
            end else begin
              res_idx_d = div_res.quo[11:0];
              if (div_res.rem != 16'd0) begin
                res_st_d = bfba_pkg::ST_MISALIGN;
              end
            end
            state_d = S_OUT;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (row_free != 8'h00) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(8'h80 >> first_k);
          cnt_d     = cnt_q - CW'(1);
          idx_d     = 13'({row_q, 3'b000}) + 13'(first_k);
          state_d   = S_MUL;
        end else begin
          row_d   = row_q + RW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_CK;
      end
      S_FREE_CK: begin
        if ((ram_rdata & q_mask) != 8'h00) begin
          res_st_d = bfba_pkg::ST_NOT_USED;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = div_res.quo[RW+2:3];
          ram_wdata = ram_rdata | q_mask;
          cnt_d     = cnt_q + CW'(1);
        end
        state_d = S_OUT;
      end
      S_MUL: begin
        prod_d  = {16'b0, idx_q} * {13'b0, bs_eff};
        state_d = S_ADDR;
      end
      S_ADDR: begin
        res_addr_d = base_q + MapBytes + {3'b0, prod_q};
        res_idx_d  = idx_q[11:0];
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_d.status        = res_st_q;
          out_d.block_address = res_addr_q;
          out_d.block_index   = res_idx_q;
          out_d.all_free      = (cnt_q == NumBlkC);
          out_d.all_used      = (cnt_q == '0);
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      cnt_q       <= NumBlkC;
      base_q      <= 32'd0;
      bsize_q     <= 16'd16;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == bfba_pkg::REG_BASE_ADDRESS) begin
          base_q <= cfg_data_i;
        end else if (cfg_index_i == bfba_pkg::REG_BLOCK_SIZE) begin
          bsize_q <= cfg_data_i[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    off_q      <= off_d;
    span_q     <= span_d;
    idx_q      <= idx_d;
    prod_q     <= prod_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_idx_q  <= res_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bfba_ram #(
    .Width(8),
    .Depth(Rows)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bfba_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(off_in),
    .divisor_i (bs_eff),
    .res_o     (div_res)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bfba_checker.sv
`default_nettype none
module bfba_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire bfba_pkg::out_t out_data_o
);

  // A held result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Only one request is in flight.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.all_free && out_data_o.all_used))
    else $error("map reported both all free and all used");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == bfba_pkg::ST_FULL |->
      out_data_o.all_used && out_data_o.block_address == 32'd0 &&
      out_data_o.block_index == 12'd0)
    else $error("full result inconsistent");

endmodule

bind bitmap_fixed_block_allocator_core bfba_checker u_bfba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

FILE: tb/bitmap_fixed_block_allocator_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bitmap_fixed_block_allocator_checker #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire bfba_pkg::in_t  in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire bfba_pkg::out_t out_data_i,
  input  wire logic           cfg_valid_i,
  input  wire logic           cfg_ready_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [NUM_BLOCKS-1:0] free_bits;
  logic [31:0]           base_q;
  logic [15:0]           size_q;
  bfba_pkg::out_t        expected_q[$];

  function automatic bfba_pkg::out_t predict_request(input bfba_pkg::in_t req);
    bfba_pkg::out_t res;
    logic [31:0] bs;
    logic [31:0] off;
    logic [31:0] idx;
    int          found;
    bs = (size_q == 16'd0) ? 32'd1 : {16'd0, size_q};
    off = req.address - base_q - NUM_BLOCKS / 8;
    res = '0;
    res.status = bfba_pkg::ST_OK;
    found = -1;
    case (req.op)
      bfba_pkg::OP_ALLOC: begin
        for (int i = NUM_BLOCKS - 1; i >= 0; i--)
          if (free_bits[i]) found = i;
        if (found < 0) begin
          res.status = bfba_pkg::ST_FULL;
        end else begin
          free_bits[found] = 1'b0;
          res.block_index = 12'(found);
          res.block_address = base_q + NUM_BLOCKS / 8 + found * bs;
        end
      end
      bfba_pkg::OP_FREE: begin
        idx = off / bs;
        if (idx >= NUM_BLOCKS) begin
          res.status = bfba_pkg::ST_RANGE;
        end else begin
          res.block_index = idx[11:0];
          if (free_bits[idx]) res.status = bfba_pkg::ST_NOT_USED;
          else free_bits[idx] = 1'b1;
        end
      end
      bfba_pkg::OP_CONTAINS: begin
        if (off >= NUM_BLOCKS * bs) begin
          res.status = bfba_pkg::ST_RANGE;
        end else begin
          res.block_index = 12'(off / bs);
          if (off % bs != 0) res.status = bfba_pkg::ST_MISALIGN;
        end
      end
      default: ;
    endcase
    res.all_free = &free_bits;
    res.all_used = ~|free_bits;
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bfba_pkg::out_t exp_beat;
    if (!rst_ni) begin
      free_bits = '1;
      base_q <= '0;
      size_q <= 16'd16;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bfba_pkg::REG_BASE_ADDRESS) base_q <= cfg_data_i;
        else if (cfg_index_i == bfba_pkg::REG_BLOCK_SIZE) size_q <= cfg_data_i[15:0];
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_request(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_beat = expected_q.pop_front();
          if (exp_beat !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_beat, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/bitmap_fixed_block_allocator_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module bitmap_fixed_block_allocator_core_tb;

  localparam int NUM_BLOCKS = 64;
  // Headroom past the last expected result before the verdict.
  localparam int DRAIN_CYCLES = 100;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  bfba_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  bfba_pkg::out_t out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index_i = '0;
  logic [31:0]    cfg_data_i = '0;
  int             fail_count;
  int             pending;

  // The receiver's stall behavior is chosen by the stimulus process through these.
  bit          hold_results = 1'b0;
  bit          random_stall = 1'b1;

  // Shadow copies of the current settings, used to aim addresses at real blocks.
  logic [31:0] cur_base = '0;
  logic [15:0] cur_size = 16'd16;

  always #2 clk_i = ~clk_i;

  bitmap_fixed_block_allocator_core #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  bitmap_fixed_block_allocator_checker #(.NUM_BLOCKS(NUM_BLOCKS)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Receiver: random stall stretches, or a held stall while hold_results is set.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        out_stall_i <= 1'b1;
      end else if (random_stall && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = gap_length() + 1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One request beat: present it at a falling edge, hold until taken, then,
  // if idle is set, idle for a random gap. Valid stays high across back-to-back beats.
  task automatic send_request(input logic [1:0] op, input logic [31:0] addr, input bit idle);
    int n;
    in_valid_i <= 1'b1;
    in_data_i <= '{op: op, address: addr};
    do @(posedge clk_i); while (in_stall_o);
    n = idle ? gap_length() : 0;
    @(negedge clk_i);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == bfba_pkg::REG_BASE_ADDRESS) cur_base = value;
    else cur_size = value[15:0];
    @(negedge clk_i);
  endtask

  // Waits until every predicted result has arrived, then lets the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Address of block idx under the current settings, plus a byte offset.
  function automatic logic [31:0] block_addr(input int idx, input logic [31:0] off);
    logic [31:0] bs;
    bs = (cur_size == 0) ? 32'd1 : {16'd0, cur_size};
    return cur_base + NUM_BLOCKS / 8 + idx * bs + off;
  endfunction

  // Random request, mostly aimed at live blocks, sometimes pure noise.
  task automatic random_request(input bit idle);
    int          sel;
    logic [1:0]  op;
    logic [31:0] addr;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      op = bfba_pkg::OP_ALLOC;
      addr = $urandom();
    end else if (sel < 70) begin
      op = bfba_pkg::OP_FREE;
      addr = block_addr($urandom_range(0, NUM_BLOCKS - 1),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 0);
    end else if (sel < 88) begin
      op = bfba_pkg::OP_CONTAINS;
      addr = block_addr($urandom_range(0, NUM_BLOCKS), ($urandom_range(0, 2) == 0) ? 1 : 0);
    end else begin
      op = 2'($urandom_range(0, 3));
      addr = $urandom();
    end
    send_request(op, addr, idle);
  endtask

  // Stimulus.
  initial begin
    logic [15:0] sizes[6];
    logic [31:0] bases[6];
    int          k;
    sizes = '{16'd16, 16'd1, 16'd0, 16'd65535, 16'd7, 16'd64};
    bases = '{32'd0, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 32'h1234_5678, 32'd100};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full map, over-full, frees of every kind, contains edges, unused opcode.
    for (k = 0; k < NUM_BLOCKS; k++) send_request(bfba_pkg::OP_ALLOC, '0, k < 4);
    send_request(bfba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1);
    send_request(bfba_pkg::OP_FREE, block_addr(3, 5), 1'b1);
    send_request(bfba_pkg::OP_FREE, block_addr(3, 0), 1'b1);
    send_request(bfba_pkg::OP_FREE, 32'd0, 1'b1);
    send_request(bfba_pkg::OP_FREE, 32'hFFFF_FFFF, 1'b1);
    send_request(bfba_pkg::OP_FREE, block_addr(NUM_BLOCKS, 0), 1'b1);
    send_request(bfba_pkg::OP_CONTAINS, block_addr(NUM_BLOCKS - 1, 15), 1'b1);
    send_request(bfba_pkg::OP_CONTAINS, block_addr(NUM_BLOCKS, 0), 1'b1);
    send_request(bfba_pkg::OP_CONTAINS, block_addr(0, 0), 1'b1);
    send_request(bfba_pkg::OP_CONTAINS, block_addr(0, 1), 1'b1);
    send_request(bfba_pkg::OP_CONTAINS, 32'd7, 1'b1);
    send_request(2'd3, 32'hFFFF_FFFF, 1'b1);
    send_request(bfba_pkg::OP_ALLOC, '0, 1'b1);
    for (k = 0; k < NUM_BLOCKS; k++) send_request(bfba_pkg::OP_FREE, block_addr(k, 0), 1'b0);
    wait_drained();

    // Random phases under several settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      write_register(bfba_pkg::REG_BASE_ADDRESS, bases[ph]);
      write_register(bfba_pkg::REG_BLOCK_SIZE, {16'd0, sizes[ph]});
      for (k = 0; k < 100; k++) random_request(1'b1);
      if (ph == 2) begin
        // Receiver holds off for a long stretch while requests keep coming.
        hold_results = 1'b1;
        fork
          begin
            repeat (400) @(negedge clk_i);
            hold_results = 1'b0;
          end
          for (k = 0; k < 8; k++) random_request(1'b0);
        join
      end
      wait_drained();
    end
    random_stall = 1'b0;
    for (k = 0; k < 20; k++) random_request(1'b0);
    wait_drained();

    if (fail_count == 0) $display("[bitmap_fixed_block_allocator_core] OK");
    else $display("[bitmap_fixed_block_allocator_core] ERROR");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("[bitmap_fixed_block_allocator_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
